### rtl/bwe_pkg.sv
// Shared types, codes and constants of the blend weight engine.
package bwe_pkg;

  localparam int unsigned DEF_MAX_POINTS       = 16;
  localparam int unsigned DEF_WEIGHT_FRAC_BITS = 16;

  localparam int unsigned X_W       = 16;
  localparam int unsigned RAW_W     = 28;   // 2^40 / (dist + 0.1) stays below 2^28
  localparam int unsigned INV_SHIFT = 40;
  localparam int unsigned TENTH_Q16 = 6554;
  localparam int unsigned PADDR_W   = 3;

  localparam logic [1:0] ACT_APPEND = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;

  localparam logic [1:0] MODE_LINEAR = 2'd0;
  localparam logic [1:0] MODE_IDW    = 2'd1;
  localparam logic [1:0] MODE_ADD    = 2'd2;

  localparam logic [1:0] ST_ADD_OK     = 2'd0;
  localparam logic [1:0] ST_ADD_REFUSE = 2'd1;
  localparam logic [1:0] ST_WEIGHT     = 2'd2;

  localparam logic REG_BLEND_MODE = 1'b0;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_INS_SCAN,
    OP_SHIFT_INIT,
    OP_SHIFT,
    OP_WRITE,
    OP_REFUSE,
    OP_SCAN1D,
    OP_DIV_T_START,
    OP_T_LATCH,
    OP_EMIT_ONE_L,
    OP_EMIT_ONE_R,
    OP_EMIT_L,
    OP_EMIT_R,
    OP_CLIPSCAN,
    OP_PTR_CLR,
    OP_PTR_INC,
    OP_HALF_EMIT,
    OP_SQ,
    OP_SQRT_START,
    OP_RAW_START,
    OP_RAW_STORE,
    OP_W_START,
    OP_W_EMIT
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       full;
    logic       cnt_zero;
    logic       cnt_lt2;
    logic       ptr_end;
    logic       shift_done;
    logic       clip_at_ptr;
    logic       any_clip;
    logic       l_ok;
    logic       r_ok;
    logic       same;
    logic       range_pos;
    logic       num_pos;
    logic       div_busy;
    logic       sqrt_busy;
  } stat_t;

endpackage

### rtl/bwe_div.sv
// Restoring divider, one quotient bit per cycle.
module bwe_div #(
  parameter int unsigned NUM_W = 56,
  parameter int unsigned DEN_W = 33
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic [NUM_W-1:0] quot_o
);
  localparam int unsigned CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quot_q;
  logic [DEN_W:0]   rem_q, rem_sh, diff;
  logic [DEN_W-1:0] den_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q;

  assign rem_sh = {rem_q[DEN_W-1:0], quot_q[NUM_W-1]};
  assign diff   = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(NUM_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= num_i;
      rem_q  <= '0;
      den_q  <= den_i;
    end else if (busy_q) begin
      if (!diff[DEN_W]) begin
        rem_q  <= diff;
        quot_q <= {quot_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        quot_q <= {quot_q[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;
endmodule

### rtl/bwe_sqrt.sv
// Integer square root, one root bit per cycle.
module bwe_sqrt #(
  parameter int unsigned IN_W = 50
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [IN_W-1:0]   rad_i,
  output logic              busy_o,
  output logic [IN_W/2-1:0] root_o
);
  localparam int unsigned OW = IN_W / 2;
  localparam int unsigned CW = $clog2(OW + 1);

  logic [IN_W-1:0] rad_q;
  logic [OW+1:0]   rem_q, rem_sh, trial;
  logic [OW-1:0]   root_q;
  logic [CW-1:0]   cnt_q;
  logic            busy_q;

  assign rem_sh = {rem_q[OW-1:0], rad_q[IN_W-1:IN_W-2]};
  assign trial  = {root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(OW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= {rad_q[IN_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[OW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[OW-2:0], 1'b0};
      end
    end
  end

  assign busy_o = busy_q;
  assign root_o = root_q;
endmodule

### rtl/bwe_datapath.sv
// Point table, scan registers, arithmetic units and result register.
module bwe_datapath #(
  parameter int unsigned MAX_POINTS       = bwe_pkg::DEF_MAX_POINTS,
  parameter int unsigned WEIGHT_FRAC_BITS = bwe_pkg::DEF_WEIGHT_FRAC_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bwe_pkg::cmd_t       cmd_i,
  output bwe_pkg::stat_t      stat_o,
  input  logic [1:0]          action_i,
  input  logic signed [15:0]  x_value_i,
  input  logic signed [15:0]  y_value_i,
  input  logic                has_clip_i,
  output logic                result_valid_o,
  output logic [3:0]          point_index_o,
  output logic [16:0]         weight_o,
  output logic [1:0]          status_o,
  output logic                last_o
);
  import bwe_pkg::*;

  localparam int unsigned IDX_W  = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int unsigned WF     = WEIGHT_FRAC_BITS;
  localparam int unsigned TOT_W  = RAW_W + CNT_W;
  localparam int unsigned NUM_W  = (RAW_W + WF > INV_SHIFT + 1) ? RAW_W + WF : INV_SHIFT + 1;
  localparam int unsigned D2_W   = 2 * X_W + 2;
  localparam int unsigned RAD_W  = D2_W + 16;
  localparam int unsigned ROOT_W = RAD_W / 2;

  logic signed [X_W-1:0] x_mem [MAX_POINTS];
  logic signed [X_W-1:0] y_mem [MAX_POINTS];
  logic                  clip_mem [MAX_POINTS];
  logic [RAW_W-1:0]      raw_mem [MAX_POINTS];

  logic [1:0]            act_q;
  logic signed [X_W-1:0] xq, yq;
  logic                  clipq;
  logic [CNT_W-1:0]      ptr_q, cnt_q;
  logic [IDX_W-1:0]      pos_q, l_idx_q, r_idx_q, lastclip_q;
  logic                  found_q, l_ok_q, r_ok_q, l_clip_q, r_clip_q, any_clip_q;
  logic signed [X_W-1:0] lx_q, rx_q;
  logic [D2_W-1:0]       sqx_q, sqy_q;
  logic [WF:0]           t_q;
  logic [TOT_W-1:0]      total_q;

  logic                  res_valid_q, res_valid_d, res_last_q, res_last_d;
  logic [3:0]            res_idx_q, res_idx_d;
  logic [16:0]           res_w_q, res_w_d;
  logic [1:0]            res_st_q, res_st_d;

  logic [IDX_W-1:0]      ptr_idx, ptr_m1, rd_addr;
  logic signed [X_W-1:0] x_rd, y_rd;
  logic                  clip_rd;
  logic [RAW_W-1:0]      raw_rd;
  logic signed [X_W:0]   num_s, range_s, dx, dy;
  logic signed [D2_W-1:0] sqx_d, sqy_d;
  logic [D2_W-1:0]       d2;
  logic [WF:0]           one_w, t_d, wv;
  logic [NUM_W-1:0]      div_num, div_q;
  logic [TOT_W-1:0]      div_den;
  logic                  div_start, div_busy, sqrt_busy;
  logic [ROOT_W-1:0]     dist_root;
  logic [IDX_W-1:0]      emit_idx;
  logic [IDX_W+3:0]      idx_ext;
  logic [WF+17:0]        w_ext;
  op_e                   op;

  assign op      = cmd_i.op;
  assign ptr_idx = ptr_q[IDX_W-1:0];
  assign ptr_m1  = ptr_idx - IDX_W'(1);
  assign rd_addr = (op == OP_SHIFT) ? ptr_m1 : ptr_idx;
  assign x_rd    = x_mem[rd_addr];
  assign y_rd    = y_mem[rd_addr];
  assign clip_rd = clip_mem[rd_addr];
  assign raw_rd  = raw_mem[rd_addr];

  assign num_s   = {xq[X_W-1], xq} - {lx_q[X_W-1], lx_q};
  assign range_s = {rx_q[X_W-1], rx_q} - {lx_q[X_W-1], lx_q};
  assign dx      = {x_rd[X_W-1], x_rd} - {xq[X_W-1], xq};
  assign dy      = {y_rd[X_W-1], y_rd} - {yq[X_W-1], yq};
  assign sqx_d   = dx * dx;
  assign sqy_d   = dy * dy;
  assign d2      = sqx_q + sqy_q;
  assign one_w   = {1'b1, {WF{1'b0}}};

  always_comb begin
    t_d = '0;
    if (!num_s[X_W] && (num_s != '0)) begin
      t_d = (div_q > (NUM_W'(1) << WF)) ? one_w : div_q[WF:0];
    end
  end

  // divider operand selection
  assign div_start = (op == OP_DIV_T_START) || (op == OP_RAW_START) || (op == OP_W_START);
  always_comb begin
    case (op)
      OP_DIV_T_START: begin
        div_num = NUM_W'(num_s[X_W-1:0]) << WF;
        div_den = TOT_W'(range_s[X_W-1:0]);
      end
      OP_RAW_START: begin
        div_num = NUM_W'(1) << INV_SHIFT;
        div_den = TOT_W'(dist_root) + TOT_W'(TENTH_Q16);
      end
      default: begin
        div_num = NUM_W'(raw_rd) << WF;
        div_den = total_q;
      end
    endcase
  end

  bwe_div #(.NUM_W(NUM_W), .DEN_W(TOT_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quot_o  (div_q)
  );

  bwe_sqrt #(.IN_W(RAD_W)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (op == OP_SQRT_START),
    .rad_i   ({d2, 16'b0}),
    .busy_o  (sqrt_busy),
    .root_o  (dist_root)
  );

  // table writes
  always_ff @(posedge clk_i) begin
    case (op)
      OP_SHIFT: begin
        x_mem[ptr_idx]    <= x_rd;
        y_mem[ptr_idx]    <= y_rd;
        clip_mem[ptr_idx] <= clip_rd;
      end
      OP_WRITE: begin
        x_mem[pos_q]    <= xq;
        y_mem[pos_q]    <= (act_q == ACT_INSERT) ? '0 : yq;
        clip_mem[pos_q] <= clipq;
      end
      OP_RAW_STORE: raw_mem[ptr_idx] <= div_q[RAW_W-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ptr_q <= '0;
    end else begin
      case (op)
        OP_LOAD, OP_PTR_CLR: ptr_q <= '0;
        OP_SHIFT_INIT:       ptr_q <= cnt_q;
        OP_SHIFT:            ptr_q <= ptr_q - CNT_W'(1);
        OP_WRITE:            cnt_q <= cnt_q + CNT_W'(1);
        OP_INS_SCAN, OP_SCAN1D, OP_CLIPSCAN, OP_PTR_INC, OP_HALF_EMIT,
        OP_RAW_STORE, OP_W_EMIT: ptr_q <= ptr_q + CNT_W'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (op)
      OP_LOAD: begin
        act_q      <= action_i;
        xq         <= x_value_i;
        yq         <= y_value_i;
        clipq      <= has_clip_i;
        pos_q      <= cnt_q[IDX_W-1:0];
        found_q    <= 1'b0;
        l_ok_q     <= 1'b0;
        r_ok_q     <= 1'b0;
        any_clip_q <= 1'b0;
        total_q    <= '0;
      end
      OP_INS_SCAN: begin
        if (!found_q && (x_rd > xq)) begin
          pos_q   <= ptr_idx;
          found_q <= 1'b1;
        end
      end
      OP_SCAN1D: begin
        if (x_rd <= xq) begin
          l_ok_q   <= 1'b1;
          l_idx_q  <= ptr_idx;
          lx_q     <= x_rd;
          l_clip_q <= clip_rd;
        end
        if ((x_rd >= xq) && !r_ok_q) begin
          r_ok_q   <= 1'b1;
          r_idx_q  <= ptr_idx;
          rx_q     <= x_rd;
          r_clip_q <= clip_rd;
        end
      end
      OP_T_LATCH: t_q <= t_d;
      OP_CLIPSCAN: begin
        if (clip_rd) begin
          any_clip_q <= 1'b1;
          lastclip_q <= ptr_idx;
        end
      end
      OP_SQ: begin
        sqx_q <= sqx_d;
        sqy_q <= sqy_d;
      end
      OP_RAW_STORE: total_q <= total_q + TOT_W'(div_q[RAW_W-1:0]);
      default: ;
    endcase
  end

  // result selection
  always_comb begin
    res_valid_d = 1'b0;
    res_last_d  = 1'b1;
    res_st_d    = ST_WEIGHT;
    emit_idx    = ptr_idx;
    wv          = '0;
    case (op)
      OP_WRITE: begin
        res_valid_d = 1'b1;
        res_st_d    = ST_ADD_OK;
        emit_idx    = pos_q;
      end
      OP_REFUSE: begin
        res_valid_d = 1'b1;
        res_st_d    = ST_ADD_REFUSE;
        emit_idx    = '0;
      end
      OP_EMIT_ONE_L: begin
        res_valid_d = l_clip_q;
        emit_idx    = l_idx_q;
        wv          = one_w;
      end
      OP_EMIT_ONE_R: begin
        res_valid_d = r_clip_q;
        emit_idx    = r_idx_q;
        wv          = one_w;
      end
      OP_EMIT_L: begin
        res_valid_d = l_clip_q;
        res_last_d  = !r_clip_q;
        emit_idx    = l_idx_q;
        wv          = one_w - t_q;
      end
      OP_EMIT_R: begin
        res_valid_d = r_clip_q;
        emit_idx    = r_idx_q;
        wv          = t_q;
      end
      OP_HALF_EMIT: begin
        res_valid_d = clip_rd;
        res_last_d  = (ptr_idx == lastclip_q);
        wv          = one_w >> 1;
      end
      OP_W_EMIT: begin
        res_valid_d = 1'b1;
        res_last_d  = (ptr_idx == lastclip_q);
        wv          = div_q[WF:0];
      end
      default: ;
    endcase
    idx_ext  = (IDX_W + 4)'(emit_idx);
    w_ext    = (WF + 18)'(wv);
    res_idx_d = idx_ext[3:0];
    res_w_d   = w_ext[16:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_idx_q  <= res_idx_d;
    res_w_q    <= res_w_d;
    res_st_q   <= res_st_d;
    res_last_q <= res_last_d;
  end

  assign result_valid_o = res_valid_q;
  assign point_index_o  = res_idx_q;
  assign weight_o       = res_w_q;
  assign status_o       = res_st_q;
  assign last_o         = res_last_q;

  always_comb begin
    stat_o.action      = act_q;
    stat_o.full        = (cnt_q == CNT_W'(MAX_POINTS));
    stat_o.cnt_zero    = (cnt_q == '0);
    stat_o.cnt_lt2     = (cnt_q < CNT_W'(2));
    stat_o.ptr_end     = (ptr_q == cnt_q);
    stat_o.shift_done  = (ptr_q == CNT_W'(pos_q));
    stat_o.clip_at_ptr = clip_rd;
    stat_o.any_clip    = any_clip_q;
    stat_o.l_ok        = l_ok_q;
    stat_o.r_ok        = r_ok_q;
    stat_o.same        = (l_idx_q == r_idx_q);
    stat_o.range_pos   = !range_s[X_W] && (range_s != '0);
    stat_o.num_pos     = !num_s[X_W] && (num_s != '0);
    stat_o.div_busy    = div_busy;
    stat_o.sqrt_busy   = sqrt_busy;
  end
endmodule

### rtl/bwe_ctrl.sv
// Sequencer that steps the datapath through adds and queries.
module bwe_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [1:0]     mode_i,
  input  bwe_pkg::stat_t stat_i,
  output bwe_pkg::cmd_t  cmd_o,
  output logic           busy_o
);
  import bwe_pkg::*;

  typedef enum logic [16:0] {
    S_IDLE     = 17'h00001,
    S_DISPATCH = 17'h00002,
    S_INS_SCAN = 17'h00004,
    S_SHIFT    = 17'h00008,
    S_SCAN1D   = 17'h00010,
    S_DEC1D    = 17'h00020,
    S_TWAIT    = 17'h00040,
    S_EMIT_L   = 17'h00080,
    S_EMIT_R   = 17'h00100,
    S_CLIPSCAN = 17'h00200,
    S_HALF     = 17'h00400,
    S_DIST     = 17'h00800,
    S_SQRT     = 17'h01000,
    S_SWAIT    = 17'h02000,
    S_RWAIT    = 17'h04000,
    S_NORM     = 17'h08000,
    S_WWAIT    = 17'h10000
  } state_e;

  state_e state_q, state_d;
  op_e    op;

  always_comb begin
    state_d = state_q;
    op      = OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op      = OP_LOAD;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_d = S_IDLE;
        case (stat_i.action)
          ACT_APPEND, ACT_INSERT: begin
            if (stat_i.full) begin
              op = OP_REFUSE;
            end else if (stat_i.action == ACT_APPEND) begin
              op = OP_WRITE;
            end else begin
              state_d = S_INS_SCAN;
            end
          end
          ACT_QUERY: begin
            if (!stat_i.cnt_zero) begin
              case (mode_i)
                MODE_LINEAR: state_d = S_SCAN1D;
                MODE_IDW:    state_d = stat_i.cnt_lt2 ? S_SCAN1D : S_CLIPSCAN;
                MODE_ADD:    state_d = S_CLIPSCAN;
                default:     state_d = S_IDLE;
              endcase
            end
          end
          default: ;
        endcase
      end
      S_INS_SCAN: begin
        if (stat_i.ptr_end) begin
          op      = OP_SHIFT_INIT;
          state_d = S_SHIFT;
        end else begin
          op = OP_INS_SCAN;
        end
      end
      S_SHIFT: begin
        if (stat_i.shift_done) begin
          op      = OP_WRITE;
          state_d = S_IDLE;
        end else begin
          op = OP_SHIFT;
        end
      end
      S_SCAN1D: begin
        if (stat_i.ptr_end) begin
          state_d = S_DEC1D;
        end else begin
          op = OP_SCAN1D;
        end
      end
      S_DEC1D: begin
        state_d = S_IDLE;
        if (stat_i.l_ok && stat_i.r_ok && !stat_i.same) begin
          if (stat_i.range_pos) begin
            if (stat_i.num_pos) begin
              op      = OP_DIV_T_START;
              state_d = S_TWAIT;
            end else begin
              op      = OP_T_LATCH;
              state_d = S_EMIT_L;
            end
          end
        end else if (stat_i.l_ok) begin
          op = OP_EMIT_ONE_L;
        end else if (stat_i.r_ok) begin
          op = OP_EMIT_ONE_R;
        end
      end
      S_TWAIT: begin
        if (!stat_i.div_busy) begin
          op      = OP_T_LATCH;
          state_d = S_EMIT_L;
        end
      end
      S_EMIT_L: begin
        op      = OP_EMIT_L;
        state_d = S_EMIT_R;
      end
      S_EMIT_R: begin
        op      = OP_EMIT_R;
        state_d = S_IDLE;
      end
      S_CLIPSCAN: begin
        if (stat_i.ptr_end) begin
          op = OP_PTR_CLR;
          if (!stat_i.any_clip) begin
            state_d = S_IDLE;
          end else begin
            state_d = (mode_i == MODE_IDW) ? S_DIST : S_HALF;
          end
        end else begin
          op = OP_CLIPSCAN;
        end
      end
      S_HALF: begin
        if (stat_i.ptr_end) begin
          state_d = S_IDLE;
        end else begin
          op = OP_HALF_EMIT;
        end
      end
      S_DIST: begin
        if (stat_i.ptr_end) begin
          op      = OP_PTR_CLR;
          state_d = S_NORM;
        end else if (!stat_i.clip_at_ptr) begin
          op = OP_PTR_INC;
        end else begin
          op      = OP_SQ;
          state_d = S_SQRT;
        end
      end
      S_SQRT: begin
        op      = OP_SQRT_START;
        state_d = S_SWAIT;
      end
      S_SWAIT: begin
        if (!stat_i.sqrt_busy) begin
          op      = OP_RAW_START;
          state_d = S_RWAIT;
        end
      end
      S_RWAIT: begin
        if (!stat_i.div_busy) begin
          op      = OP_RAW_STORE;
          state_d = S_DIST;
        end
      end
      S_NORM: begin
        if (stat_i.ptr_end) begin
          state_d = S_IDLE;
        end else if (!stat_i.clip_at_ptr) begin
          op = OP_PTR_INC;
        end else begin
          op      = OP_W_START;
          state_d = S_WWAIT;
        end
      end
      S_WWAIT: begin
        if (!stat_i.div_busy) begin
          op      = OP_W_EMIT;
          state_d = S_NORM;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o.op = op;
  assign busy_o   = (state_q != S_IDLE);
endmodule

### rtl/blend_weight_engine_core.sv
// Blend weight engine: point table with 1D, inverse-distance and additive weighting.
//
// Command channel: an item (action, x, y, has_clip) is taken when start is high and
// busy is low. Results leave on result_valid_o, one cycle each, with last_o on the
// final one; the receiver cannot stall, and a new item may be taken while the last
// result is still on the ports. An append or a refused add needs no table search; an
// insert searches the table and then moves its entries, one entry a cycle.
// A linear query scans the table, then emits one weight or a weight pair, which may
// need the interpolation divider. An additive query scans the table twice.
// An inverse-distance query runs, for each of C points with a clip, the 25-step
// square root once and the bit-serial divider (NUM_W = max(41, 28 + WEIGHT_FRAC_BITS)
// steps) twice; both units are shared by every point.
// The blend_mode register sits at byte address 0 of the APB port.
// Reset empties the table and selects linear mode; table contents are left as they
// are and are not read until rewritten.
module blend_weight_engine_core #(
  parameter int unsigned MAX_POINTS       = bwe_pkg::DEF_MAX_POINTS,
  parameter int unsigned WEIGHT_FRAC_BITS = bwe_pkg::DEF_WEIGHT_FRAC_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  action_i,
  input  logic signed [15:0]          x_value_i,
  input  logic signed [15:0]          y_value_i,
  input  logic                        has_clip_i,
  output logic                        result_valid_o,
  output logic [3:0]                  point_index_o,
  output logic [16:0]                 weight_o,
  output logic [1:0]                  status_o,
  output logic                        last_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bwe_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import bwe_pkg::*;

  logic [1:0] mode_q;
  logic       cfg_wr;
  cmd_t       cmd;
  stat_t      stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_LINEAR;
    end else if (cfg_wr && (paddr[2] == REG_BLEND_MODE)) begin
      mode_q <= pwdata[1:0];
    end
  end

  assign prdata = (paddr[2] == REG_BLEND_MODE) ? 32'(mode_q) : '0;

  bwe_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .mode_i  (mode_q),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  bwe_datapath #(
    .MAX_POINTS       (MAX_POINTS),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .action_i       (action_i),
    .x_value_i      (x_value_i),
    .y_value_i      (y_value_i),
    .has_clip_i     (has_clip_i),
    .result_valid_o (result_valid_o),
    .point_index_o  (point_index_o),
    .weight_o       (weight_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );
endmodule

### rtl/bwe_checker.sv
// Port-level checks of the blend weight engine, bound to the top level.
module bwe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        result_valid_o,
  input logic [16:0] weight_o,
  input logic [1:0]  status_o,
  input logic        last_o,
  input logic        pready
);
  import bwe_pkg::*;

  // an accepted item always keeps the block busy for the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("busy not raised after accept");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (status_o == ST_ADD_OK || status_o == ST_ADD_REFUSE ||
                        status_o == ST_WEIGHT)) else $error("bad status code");

  // an add answers with one item of weight zero
  a_add_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (status_o != ST_WEIGHT) |-> last_o && (weight_o == '0))
    else $error("add result malformed");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready) else $error("pready dropped");
endmodule

bind blend_weight_engine_core bwe_checker u_bwe_checker (.*);
